FILE: rtl/aff2i_pkg.sv
// Shared types and constants for the 2D affine inverse core.
// No dependencies; imported by every module of the core.
package aff2i_pkg;

  // Six result lanes: four linear terms and two translation terms
  localparam int unsigned LANES = 6;
  // Quotient bits developed by the cell chain; larger quotients flag overflow
  localparam int unsigned QBITS = 33;
  // Cycles from the accepting edge to the edge ending the done cycle
  localparam int unsigned LATENCY = QBITS + 4;

  localparam logic [31:0] POS_LIMIT = 32'h7FFF_FFFF;
  localparam logic [31:0] NEG_LIMIT = 32'h8000_0000;

  typedef logic signed [31:0] word_t;

  // Per-lane long-division state
  typedef struct packed {
    logic [63:0]      rem;   // partial remainder, below divisor unless ovf is set
    logic [QBITS-1:0] low;   // dividend bits still to shift in
    logic [QBITS-1:0] quo;   // quotient bits developed so far
    logic             neg;   // result sign
    logic             ovf;   // quotient known to exceed QBITS bits
  } lane_t;

  // Data handed from cell to cell
  typedef struct packed {
    logic                  singular;
    logic [63:0]           dmag;
    lane_t [LANES-1:0]     lane;
  } stage_t;

endpackage

FILE: rtl/affine2d_inverse_core.sv
// Top level of the 2D affine inverse core: front end, divider cell chain, back end.
// Depends on aff2i_pkg, aff2i_front, aff2i_cell, aff2i_back.
//
// Usage:
//   Drive the six coefficients of x' = A x + t on in_*_i and raise start for
//   one cycle; the transfer happens at a rising edge with start high and busy
//   low. busy stays low, so a new transform may be started every cycle.
//   The result (inverse linear part, inverse translation, singular_o,
//   saturated_o) appears on the out ports for exactly one cycle with done_o
//   high, and is taken at the edge that ends that cycle. The path from the
//   accepting edge runs through three front stages (products, determinant,
//   division setup), one cell per quotient bit (33 cells) and one rounding
//   stage. Throughput is one item per cycle; each cell works on a different
//   item.
//   The receiver cannot stall; results must be taken when done_o is high.
//   Reset clears all valid bits; items in flight are dropped and done_o
//   stays low until new items reach the end of the chain.
module affine2d_inverse_core #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  output logic             busy,
  input  aff2i_pkg::word_t in_a11_i,
  input  aff2i_pkg::word_t in_a12_i,
  input  aff2i_pkg::word_t in_a21_i,
  input  aff2i_pkg::word_t in_a22_i,
  input  aff2i_pkg::word_t in_tx_i,
  input  aff2i_pkg::word_t in_ty_i,
  output logic             done_o,
  output aff2i_pkg::word_t out_a11_o,
  output aff2i_pkg::word_t out_a12_o,
  output aff2i_pkg::word_t out_a21_o,
  output aff2i_pkg::word_t out_a22_o,
  output aff2i_pkg::word_t out_tx_o,
  output aff2i_pkg::word_t out_ty_o,
  output logic             singular_o,
  output logic             saturated_o
);
  import aff2i_pkg::*;

  logic   vld [QBITS+1];
  stage_t stg [QBITS+1];
  word_t  res [LANES];

  assign busy = 1'b0;

  aff2i_front #(
    .FRAC_BITS(FRAC_BITS)
  ) u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (start & ~busy),
    .a11_i   (in_a11_i),
    .a12_i   (in_a12_i),
    .a21_i   (in_a21_i),
    .a22_i   (in_a22_i),
    .tx_i    (in_tx_i),
    .ty_i    (in_ty_i),
    .valid_o (vld[0]),
    .stage_o (stg[0])
  );

  // Chain of divider cells, one quotient bit each
  for (genvar g = 0; g < QBITS; g++) begin : g_cell
    aff2i_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (vld[g]),
      .stage_i (stg[g]),
      .valid_o (vld[g+1]),
      .stage_o (stg[g+1])
    );
  end

  aff2i_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (vld[QBITS]),
    .stage_i     (stg[QBITS]),
    .done_o      (done_o),
    .res_o       (res),
    .singular_o  (singular_o),
    .saturated_o (saturated_o)
  );

  assign out_a11_o = res[0];
  assign out_a12_o = res[1];
  assign out_a21_o = res[2];
  assign out_a22_o = res[3];
  assign out_tx_o  = res[4];
  assign out_ty_o  = res[5];

endmodule

FILE: rtl/aff2i_front.sv
// Front end: products, determinant and numerators, then division setup.
// Depends on aff2i_pkg.
module aff2i_front #(
  parameter int unsigned FRAC_BITS = 16
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             valid_i,
  input  aff2i_pkg::word_t a11_i,
  input  aff2i_pkg::word_t a12_i,
  input  aff2i_pkg::word_t a21_i,
  input  aff2i_pkg::word_t a22_i,
  input  aff2i_pkg::word_t tx_i,
  input  aff2i_pkg::word_t ty_i,
  output logic             valid_o,
  output aff2i_pkg::stage_t stage_o
);
  import aff2i_pkg::*;

  localparam int unsigned SH_LIN = 2 * FRAC_BITS;
  localparam int unsigned SH_TR  = FRAC_BITS;

  logic [2:0] vld_q;

  // Stage 1: six products
  logic signed [63:0] p_ad_q, p_bc_q, p_dtx_q, p_bty_q, p_ctx_q, p_aty_q;
  word_t a11_1_q, a12_1_q, a21_1_q, a22_1_q;

  // Stage 2: determinant and translation numerators
  logic signed [63:0] det_q, numx_q, numy_q;
  word_t a11_2_q, a12_2_q, a21_2_q, a22_2_q;

  // Stage 3 inputs
  logic signed [63:0] num [LANES];
  logic [63:0]        dmag;
  stage_t             stage_d, stage_q;

  // Advance the valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[1:0], valid_i};
    end
  end

  // Form products, then differences, then register the lane setup
  always_ff @(posedge clk_i) begin
    p_ad_q  <= 64'(a11_i) * 64'(a22_i);
    p_bc_q  <= 64'(a12_i) * 64'(a21_i);
    p_dtx_q <= 64'(a22_i) * 64'(tx_i);
    p_bty_q <= 64'(a12_i) * 64'(ty_i);
    p_ctx_q <= 64'(a21_i) * 64'(tx_i);
    p_aty_q <= 64'(a11_i) * 64'(ty_i);
    a11_1_q <= a11_i;
    a12_1_q <= a12_i;
    a21_1_q <= a21_i;
    a22_1_q <= a22_i;

    det_q   <= p_ad_q - p_bc_q;
    numx_q  <= p_bty_q - p_dtx_q;
    numy_q  <= p_ctx_q - p_aty_q;
    a11_2_q <= a11_1_q;
    a12_2_q <= a12_1_q;
    a21_2_q <= a21_1_q;
    a22_2_q <= a22_1_q;

    stage_q <= stage_d;
  end

  // Set up each lane: sign, magnitude, overflow test, initial remainder
  always_comb begin
    logic [63:0]  nmag;
    logic [127:0] nsh;
    logic [94:0]  hi;
    num[0] = 64'(a22_2_q);
    num[1] = -64'(a12_2_q);
    num[2] = -64'(a21_2_q);
    num[3] = 64'(a11_2_q);
    num[4] = numx_q;
    num[5] = numy_q;
    dmag = det_q[63] ? 64'(-det_q) : 64'(det_q);
    stage_d.singular = (det_q == '0);
    stage_d.dmag = dmag;
    for (int i = 0; i < LANES; i++) begin
      nmag = num[i][63] ? 64'(-num[i]) : 64'(num[i]);
      if (i < 4) begin
        nsh = {64'b0, nmag} << SH_LIN;
      end else begin
        nsh = {64'b0, nmag} << SH_TR;
      end
      hi = nsh[127:QBITS];
      stage_d.lane[i].neg = num[i][63] ^ det_q[63];
      stage_d.lane[i].ovf = (hi >= {31'b0, dmag});
      stage_d.lane[i].rem = hi[63:0];
      stage_d.lane[i].low = nsh[QBITS-1:0];
      stage_d.lane[i].quo = '0;
    end
  end

  assign valid_o = vld_q[2];
  assign stage_o = stage_q;

endmodule

FILE: rtl/aff2i_cell.sv
// One divider cell: develops one quotient bit in every lane per cycle.
// Depends on aff2i_pkg.
module aff2i_cell (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  aff2i_pkg::stage_t stage_i,
  output logic              valid_o,
  output aff2i_pkg::stage_t stage_o
);
  import aff2i_pkg::*;

  logic   valid_q;
  stage_t stage_d, stage_q;

  // Shift in one dividend bit, subtract the divisor where it fits
  always_comb begin
    logic [64:0] r2;
    logic        ge;
    stage_d = stage_i;
    for (int i = 0; i < LANES; i++) begin
      r2 = {stage_i.lane[i].rem, stage_i.lane[i].low[QBITS-1]};
      ge = (r2 >= {1'b0, stage_i.dmag});
      stage_d.lane[i].rem = ge ? 64'(r2 - {1'b0, stage_i.dmag}) : r2[63:0];
      stage_d.lane[i].low = {stage_i.lane[i].low[QBITS-2:0], 1'b0};
      stage_d.lane[i].quo = {stage_i.lane[i].quo[QBITS-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    stage_q <= stage_d;
  end

  assign valid_o = valid_q;
  assign stage_o = stage_q;

endmodule

FILE: rtl/aff2i_back.sv
// Back end: round to nearest, apply sign, saturate, zero on singular.
// Depends on aff2i_pkg.
module aff2i_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              valid_i,
  input  aff2i_pkg::stage_t stage_i,
  output logic              done_o,
  output aff2i_pkg::word_t  res_o [aff2i_pkg::LANES],
  output logic              singular_o,
  output logic              saturated_o
);
  import aff2i_pkg::*;

  logic  done_q;
  word_t res_d [LANES];
  word_t res_q [LANES];
  logic  sat_d, sat_q, sing_q;

  // Round and clamp each lane
  always_comb begin
    logic        rnd;
    logic [QBITS:0] qr;
    sat_d = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      rnd = ({stage_i.lane[i].rem, 1'b0} >= {1'b0, stage_i.dmag});
      qr  = {1'b0, stage_i.lane[i].quo} + (QBITS+1)'(rnd);
      if (stage_i.lane[i].neg) begin
        if (stage_i.lane[i].ovf || qr > (QBITS+1)'(NEG_LIMIT)) begin
          res_d[i] = NEG_LIMIT;
          sat_d = 1'b1;
        end else begin
          res_d[i] = -qr[31:0];
        end
      end else begin
        if (stage_i.lane[i].ovf || qr > (QBITS+1)'(POS_LIMIT)) begin
          res_d[i] = POS_LIMIT;
          sat_d = 1'b1;
        end else begin
          res_d[i] = qr[31:0];
        end
      end
      if (stage_i.singular) begin
        res_d[i] = '0;
      end
    end
    if (stage_i.singular) begin
      sat_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q  <= res_d;
    sat_q  <= sat_d;
    sing_q <= stage_i.singular;
  end

  assign done_o      = done_q;
  assign res_o       = res_q;
  assign singular_o  = sing_q;
  assign saturated_o = sat_q;

endmodule

FILE: rtl/aff2i_checker.sv
// Port-level checks for the 2D affine inverse core, bound to the top level.
// Depends on aff2i_pkg and affine2d_inverse_core.
module aff2i_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input logic             done_o,
  input aff2i_pkg::word_t out_a11_o,
  input aff2i_pkg::word_t out_a12_o,
  input aff2i_pkg::word_t out_a21_o,
  input aff2i_pkg::word_t out_a22_o,
  input aff2i_pkg::word_t out_tx_o,
  input aff2i_pkg::word_t out_ty_o,
  input logic             singular_o,
  input logic             saturated_o
);
  import aff2i_pkg::*;

  // Every result traces back to a transfer a fixed latency earlier
  a_done_has_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, LATENCY))
    else $error("result without matching transfer");

  // Singular results are all zero and never flagged saturated
  a_singular_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && singular_o) |-> (out_a11_o == '0 && out_a12_o == '0 &&
      out_a21_o == '0 && out_a22_o == '0 && out_tx_o == '0 &&
      out_ty_o == '0 && !saturated_o))
    else $error("singular result not cleared");

  // A saturated result has at least one value at a limit
  a_sat_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (out_a11_o == POS_LIMIT || out_a11_o == NEG_LIMIT ||
       out_a12_o == POS_LIMIT || out_a12_o == NEG_LIMIT ||
       out_a21_o == POS_LIMIT || out_a21_o == NEG_LIMIT ||
       out_a22_o == POS_LIMIT || out_a22_o == NEG_LIMIT ||
       out_tx_o == POS_LIMIT || out_tx_o == NEG_LIMIT ||
       out_ty_o == POS_LIMIT || out_ty_o == NEG_LIMIT))
    else $error("saturated flag without clamped value");

endmodule

bind affine2d_inverse_core aff2i_checker u_aff2i_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .done_o      (done_o),
  .out_a11_o   (out_a11_o),
  .out_a12_o   (out_a12_o),
  .out_a21_o   (out_a21_o),
  .out_a22_o   (out_a22_o),
  .out_tx_o    (out_tx_o),
  .out_ty_o    (out_ty_o),
  .singular_o  (singular_o),
  .saturated_o (saturated_o)
);
